>>> design/axs_pkg.sv
// Shared types, opcode constants and helpers for the AArch64 xref scanner.
`default_nettype none

package axs_pkg;

    localparam int unsigned REG_COUNT = 32;
    localparam int unsigned REG_AW    = $clog2(REG_COUNT);
    localparam int unsigned VAL_W     = 64;
    localparam int unsigned OFS_W     = 31;
    localparam int unsigned INSN_W    = 32;

    localparam logic [REG_AW-1:0] ZR_INDEX = REG_AW'(REG_COUNT - 1);

    // Opcode masks and match patterns
    localparam logic [INSN_W-1:0] MASK_ADRP    = 32'h9f00_0000;
    localparam logic [INSN_W-1:0] OP_ADRP      = 32'h9000_0000;
    localparam logic [INSN_W-1:0] MASK_ADDI    = 32'hff00_0000;
    localparam logic [INSN_W-1:0] OP_ADDI      = 32'h9100_0000;
    localparam logic [INSN_W-1:0] MASK_LDR_UO  = 32'hf9c0_0000;
    localparam logic [INSN_W-1:0] OP_LDR_UO    = 32'hf940_0000;
    localparam logic [INSN_W-1:0] MASK_ADR     = 32'h9f00_0000;
    localparam logic [INSN_W-1:0] OP_ADR       = 32'h1000_0000;
    localparam logic [INSN_W-1:0] MASK_LDR_LIT = 32'hff00_0000;
    localparam logic [INSN_W-1:0] OP_LDR_LIT   = 32'h5800_0000;
    localparam logic [INSN_W-1:0] MASK_BL      = 32'hfc00_0000;
    localparam logic [INSN_W-1:0] OP_BL        = 32'h9400_0000;

    // Register file write port
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [VAL_W-1:0]  data;
    } t_wr_port;

    // One result item
    typedef struct packed {
        logic             match;
        logic [OFS_W-1:0] match_offset;
        logic             not_found;
    } t_result;

    function automatic logic is_op(input logic [INSN_W-1:0] insn,
                                   input logic [INSN_W-1:0] mask,
                                   input logic [INSN_W-1:0] pattern);
        return (insn & mask) == pattern;
    endfunction

endpackage

`default_nettype wire

>>> design/arm64_address_xref_scanner_unit.sv
// Top level of the AArch64 address cross-reference scanner.
// Usage:
//   Input channel (i_valid/o_ready): one instruction word per transfer with its
//   image offset and scan start/last flags. Output channel (o_valid/i_ready):
//   one result per input item, in order: match with its offset, or not_found
//   on the last item of a scan that had no reference, or all zero.
//   Path: the input register loads at the transfer edge and the result
//   register when that item fires; the result is presented from then on.
//   Throughput: one item per cycle unless the output stalls; the tracked register
//   table is read at the input transfer and written as the item leaves stage 1,
//   with the pending write bypassed into the read, so items stream back to back.
//   Stall: while a result waits in the output register, the item in the input
//   register holds and o_ready drops; a new item is taken in the same cycle the
//   result is taken.
//   Reset: empties both stages, clears the target register, the match flag and
//   all table valid bits. start_of_scan clears the table through its valid bits.
//   target_address must be written through i_target_address_we while idle (unchecked).
`default_nettype none

module arm64_address_xref_scanner_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_target_address_we,
    input  wire logic [axs_pkg::VAL_W-1:0]   i_target_address,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_start_of_scan,
    input  wire logic                        i_last_of_scan,
    input  wire logic [axs_pkg::OFS_W-1:0]   i_offset,
    input  wire logic [axs_pkg::INSN_W-1:0]  i_instruction_word,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_match,
    output logic      [axs_pkg::OFS_W-1:0]   o_match_offset,
    output logic                             o_not_found
);
    import axs_pkg::*;

    logic [VAL_W-1:0]  r_target;
    logic              r_match_seen;

    // stage 1: input register
    logic              r_s1_valid;
    logic              r_s1_start;
    logic              r_s1_last;
    logic [OFS_W-1:0]  r_s1_pc;
    logic [INSN_W-1:0] r_s1_insn;

    // stage 2: result register
    logic              r_o_valid;
    t_result           r_o_result;

    logic              in_xfer;
    logic              s1_fire;
    logic              s1_seen;
    logic [VAL_W-1:0]  rn_value;
    logic [VAL_W-1:0]  rd_value;
    t_wr_port          exec_wr;
    t_wr_port          wr_port;
    t_result           n_result;
    logic              n_seen;

    assign s1_fire = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_fire;
    assign in_xfer = i_valid && o_ready;

    // a start item clears the match flag before it is examined
    assign s1_seen = r_s1_start ? 1'b0 : r_match_seen;

    assign wr_port.en   = exec_wr.en && s1_fire;
    assign wr_port.addr = exec_wr.addr;
    assign wr_port.data = exec_wr.data;

    axs_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_xfer),
        .i_rd_zero  (i_start_of_scan),
        .i_rn_addr  (i_instruction_word[9:5]),
        .i_rd_addr  (i_instruction_word[4:0]),
        .i_clear    (s1_fire && r_s1_start),
        .i_wr       (wr_port),
        .o_rn_value (rn_value),
        .o_rd_value (rd_value)
    );

    axs_exec u_exec (
        .i_pc        (r_s1_pc),
        .i_insn      (r_s1_insn),
        .i_last      (r_s1_last),
        .i_seen      (s1_seen),
        .i_rn_value  (rn_value),
        .i_rd_value  (rd_value),
        .i_target    (r_target),
        .o_wr        (exec_wr),
        .o_result    (n_result),
        .o_seen_next (n_seen)
    );

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_start <= i_start_of_scan;
            r_s1_last  <= i_last_of_scan;
            r_s1_pc    <= {i_offset[OFS_W-1:2], 2'b00};
            r_s1_insn  <= i_instruction_word;
        end
        if (s1_fire) begin
            r_o_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= '0;
            r_match_seen <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_target_address_we) begin
                r_target <= i_target_address;
            end
            if (s1_fire) begin
                r_match_seen <= n_seen;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_match        = r_o_result.match;
    assign o_match_offset = r_o_result.match_offset;
    assign o_not_found    = r_o_result.not_found;

`ifndef SYNTHESIS
    // a presented match must have set the scan's match flag
    a_match_sets_seen : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_match) |-> r_match_seen)
        else $error("match shown without match flag set");

    // a result is never both a match and not-found
    a_match_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_match && o_not_found))
        else $error("match and not_found both set");

    // a table write on the same edge as a read of that entry is bypassed
    a_rn_bypass : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && in_xfer && wr_port.en && !i_start_of_scan
            && (wr_port.addr == i_instruction_word[9:5]))
        |=> (rn_value == $past(wr_port.data)))
        else $error("register table bypass lost a write");
`endif

endmodule

`default_nettype wire

>>> design/axs_regfile.sv
// Tracked register table: 32 x 64 memory, valid bits for scan clear, bypassed reads.
`default_nettype none

module axs_regfile (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic                        i_rd_zero,
    input  wire logic [axs_pkg::REG_AW-1:0]  i_rn_addr,
    input  wire logic [axs_pkg::REG_AW-1:0]  i_rd_addr,
    input  wire logic                        i_clear,
    input  wire axs_pkg::t_wr_port           i_wr,
    output logic      [axs_pkg::VAL_W-1:0]   o_rn_value,
    output logic      [axs_pkg::VAL_W-1:0]   o_rd_value
);
    import axs_pkg::*;

    logic [VAL_W-1:0]     mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [REG_COUNT-1:0] n_valid;
    logic [VAL_W-1:0]     r_rn_q;
    logic [VAL_W-1:0]     r_rd_q;
    logic                 r_rn_ok;
    logic                 r_rd_ok;
    logic                 rn_hit;
    logic                 rd_hit;

    // valid bits after this cycle's clear and write
    always_comb begin
        n_valid = i_clear ? '0 : r_valid;
        if (i_wr.en) begin
            n_valid[i_wr.addr] = 1'b1;
        end
    end

    assign rn_hit = i_wr.en && (i_wr.addr == i_rn_addr);
    assign rd_hit = i_wr.en && (i_wr.addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read data registered at input transfer; same-edge write is bypassed
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rn_q <= rn_hit ? i_wr.data : mem[i_rn_addr];
            r_rd_q <= rd_hit ? i_wr.data : mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rn_ok <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_rd_en) begin
                r_rn_ok <= !i_rd_zero && n_valid[i_rn_addr];
                r_rd_ok <= !i_rd_zero && n_valid[i_rd_addr];
            end
        end
    end

    assign o_rn_value = r_rn_ok ? r_rn_q : '0;
    assign o_rd_value = r_rd_ok ? r_rd_q : '0;

endmodule

`default_nettype wire

>>> design/axs_exec.sv
// Instruction decode, address formation and reference check for one item.
`default_nettype none

module axs_exec (
    input  wire logic [axs_pkg::OFS_W-1:0]   i_pc,
    input  wire logic [axs_pkg::INSN_W-1:0]  i_insn,
    input  wire logic                        i_last,
    input  wire logic                        i_seen,
    input  wire logic [axs_pkg::VAL_W-1:0]   i_rn_value,
    input  wire logic [axs_pkg::VAL_W-1:0]   i_rd_value,
    input  wire logic [axs_pkg::VAL_W-1:0]   i_target,
    output axs_pkg::t_wr_port                o_wr,
    output axs_pkg::t_result                 o_result,
    output logic                             o_seen_next
);
    import axs_pkg::*;

    logic [REG_AW-1:0] rd;
    logic [REG_AW-1:0] rn;
    logic [20:0]       imm21;
    logic [11:0]       imm12;
    logic [1:0]        shift;
    logic [31:0]       bl_dest;
    logic [VAL_W-1:0]  add_a;
    logic [VAL_W-1:0]  add_b;
    logic [VAL_W-1:0]  sum;
    logic [VAL_W-1:0]  wr_data;
    logic [VAL_W-1:0]  new_rd;
    logic              wr_en;
    logic              zero_wr;
    logic              check;
    logic              bl_hit;
    logic              hit;

    assign rd      = i_insn[4:0];
    assign rn      = i_insn[9:5];
    assign imm21   = {i_insn[23:5], i_insn[30:29]};
    assign imm12   = i_insn[21:10];
    assign shift   = i_insn[23:22];
    assign bl_dest = {1'b0, i_pc} + {{4{i_insn[25]}}, i_insn[25:0], 2'b00};

    always_comb begin
        add_a   = {{(VAL_W-OFS_W){1'b0}}, i_pc};
        add_b   = '0;
        wr_en   = 1'b0;
        zero_wr = 1'b0;
        check   = 1'b1;
        bl_hit  = 1'b0;
        if (is_op(i_insn, MASK_ADRP, OP_ADRP)) begin
            add_a = {{(VAL_W-OFS_W){1'b0}}, i_pc[OFS_W-1:12], 12'h000};
            add_b = {{(VAL_W-33){imm21[20]}}, imm21, 12'h000};
            wr_en = 1'b1;
        end else if (is_op(i_insn, MASK_ADDI, OP_ADDI)) begin
            if (rn == ZR_INDEX) begin
                // ADD from SP: entry forced to zero, no reference check
                wr_en   = 1'b1;
                zero_wr = 1'b1;
                check   = 1'b0;
            end else if (shift[1]) begin
                check = 1'b0;
            end else begin
                add_a = i_rn_value;
                add_b = shift[0] ? {{(VAL_W-24){1'b0}}, imm12, 12'h000}
                                 : {{(VAL_W-12){1'b0}}, imm12};
                wr_en = 1'b1;
            end
        end else if (is_op(i_insn, MASK_LDR_UO, OP_LDR_UO)) begin
            if (imm12 == '0) begin
                check = 1'b0;
            end else begin
                add_a = i_rn_value;
                add_b = {{(VAL_W-15){1'b0}}, imm12, 3'b000};
                wr_en = 1'b1;
            end
        end else if (is_op(i_insn, MASK_ADR, OP_ADR)) begin
            add_b = {{(VAL_W-21){imm21[20]}}, imm21};
            wr_en = 1'b1;
        end else if (is_op(i_insn, MASK_LDR_LIT, OP_LDR_LIT)) begin
            add_b = {{(VAL_W-21){i_insn[23]}}, i_insn[23:5], 2'b00};
            wr_en = 1'b1;
        end else if (is_op(i_insn, MASK_BL, OP_BL)) begin
            bl_hit = (i_target[VAL_W-1:32] == '0) && (bl_dest == i_target[31:0]);
        end
    end

    assign sum     = add_a + add_b;
    assign wr_data = zero_wr ? '0 : sum;
    assign new_rd  = wr_en ? wr_data : i_rd_value;
    assign hit     = bl_hit || (check && (rd != ZR_INDEX) && (new_rd == i_target));

    // once a reference is seen the rest of the scan is inert
    assign o_wr.en   = wr_en && !i_seen;
    assign o_wr.addr = rd;
    assign o_wr.data = wr_data;

    assign o_result.match        = !i_seen && hit;
    assign o_result.match_offset = (!i_seen && hit) ? i_pc : '0;
    assign o_result.not_found    = !i_seen && !hit && i_last;
    assign o_seen_next           = i_seen || hit;

endmodule

`default_nettype wire

>>> tb/tb_arm64_address_xref_scanner_unit.sv
// Self-checking testbench for the AArch64 address cross-reference scanner.
`default_nettype none

module tb_arm64_address_xref_scanner_unit;

    import axs_pkg::*;

    // Clock period is 10.
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transfer on either side
    localparam int DRAIN_CYCLES   = 4;      // input register + result register, plus slack
    localparam int IDLE_PCT       = 34;     // chance per cycle that a side idles

    localparam logic [31:0] INSN_NOP = 32'hD503_201F;

    // Reach of the PC-relative forms, in units of their immediates
    localparam longint PCREL_SPAN = 64'sd1 <<< 20;
    localparam longint LIT_SPAN   = 64'sd1 <<< 18;
    localparam int     BL_SPAN    = 1 << 25;

    // Results that can be read straight off the rules
    localparam t_result RES_IDLE        = '0;
    localparam t_result RES_NOT_FOUND   = {1'b0, 31'd0, 1'b1};
    localparam t_result RES_HIT_AT_ZERO = {1'b1, 31'd0, 1'b0};

    localparam logic [63:0] DIR_TARGET = 64'h0000_0000_0040_1230;

    // One row of the directed table. When new_tgt is set the target register
    // is rewritten (with the block idle) before the row is sent. Rows with
    // fixed set carry their own expectation; the rest go through the predictor.
    typedef struct {
        bit          new_tgt;
        logic [63:0] tgt;
        bit          s;
        bit          l;
        logic [30:0] ofs;
        logic [31:0] insn;
        bit          fixed;
        t_result     want;
    } t_dir_row;

    typedef struct {
        bit          s;
        bit          l;
        logic [30:0] ofs;
        logic [31:0] insn;
    } t_insn_item;

    // ------------------------------------------------------------------
    // DUT inputs, all known from time zero
    // ------------------------------------------------------------------
    logic        i_clk               = 1'b0;
    logic        i_rst_n             = 1'b0;
    logic        i_target_address_we = 1'b0;
    logic [63:0] i_target_address    = '0;
    logic        i_valid             = 1'b0;
    logic        i_start_of_scan     = 1'b0;
    logic        i_last_of_scan      = 1'b0;
    logic [30:0] i_offset            = '0;
    logic [31:0] i_instruction_word  = '0;
    logic        i_ready             = 1'b0;

    logic        o_ready;
    logic        o_valid;
    logic        o_match;
    logic [30:0] o_match_offset;
    logic        o_not_found;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the tracked table and the target
    // ------------------------------------------------------------------
    logic [63:0] reg_track [32];
    bit          scan_hit;
    logic [63:0] target_q;

    t_result     exp_results [$];   // one expectation per accepted instruction

    t_dir_row    dir_tab [$];
    t_insn_item  scan_q [$];
    logic [30:0] gen_pc;
    logic [4:0]  hot_reg;
    int          rand_sent;
    bit          calm;              // no idling on either side while set
    int          errs;
    int          quiet_cycles;

    arm64_address_xref_scanner_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_target_address_we (i_target_address_we),
        .i_target_address    (i_target_address),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_start_of_scan     (i_start_of_scan),
        .i_last_of_scan      (i_last_of_scan),
        .i_offset            (i_offset),
        .i_instruction_word  (i_instruction_word),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_match             (o_match),
        .o_match_offset      (o_match_offset),
        .o_not_found         (o_not_found)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Instruction encoders
    // ------------------------------------------------------------------
    // ADRP and ADR share a layout: immlo in 30:29, immhi in 23:5.
    function automatic logic [31:0] enc_pcrel(input logic [31:0] op, input logic [4:0] rd,
                                              input logic [20:0] imm);
        return op | {1'b0, imm[1:0], 5'd0, imm[20:2], rd};
    endfunction

    function automatic logic [31:0] enc_addi(input logic [4:0] rd, input logic [4:0] rn,
                                             input logic [1:0] sh, input logic [11:0] imm);
        return OP_ADDI | {8'd0, sh, imm, rn, rd};
    endfunction

    function automatic logic [31:0] enc_ldr_uo(input logic [4:0] rd, input logic [4:0] rn,
                                               input logic [11:0] imm);
        return OP_LDR_UO | {10'd0, imm, rn, rd};
    endfunction

    function automatic logic [31:0] enc_ldr_lit(input logic [4:0] rd, input logic [18:0] imm);
        return OP_LDR_LIT | {8'd0, imm, rd};
    endfunction

    function automatic logic [31:0] enc_bl(input logic [25:0] imm);
        return OP_BL | {6'd0, imm};
    endfunction

    // ------------------------------------------------------------------
    // Predictor: one instruction in, one result out
    // ------------------------------------------------------------------
    function automatic t_result xref_step(input bit s, input bit l, input logic [30:0] ofs,
                                          input logic [31:0] w);
        t_result     res;
        logic [63:0] pc;
        logic [63:0] disp;
        logic [63:0] simm21;
        logic [31:0] dest;
        logic [4:0]  rd;
        logic [4:0]  rn;
        logic [11:0] imm12;
        bit          hit;
        bit          no_check;
        res      = RES_IDLE;
        pc       = {33'd0, ofs[30:2], 2'b00};    // low two offset bits are dropped
        rd       = w[4:0];
        rn       = w[9:5];
        imm12    = w[21:10];
        simm21   = {{43{w[23]}}, w[23:5], w[30:29]};
        hit      = 1'b0;
        no_check = 1'b0;

        if (s) begin
            foreach (reg_track[i]) reg_track[i] = '0;
            scan_hit = 1'b0;
        end
        // after the first reference the rest of the scan is inert
        if (scan_hit) return res;

        if ((w & MASK_ADRP) == OP_ADRP) begin
            reg_track[rd] = (simm21 << 12) + {pc[63:12], 12'h000};
        end else if ((w & MASK_ADDI) == OP_ADDI) begin
            if (rn == ZR_INDEX) begin
                // add from SP: entry zeroed, no destination check
                reg_track[rd] = '0;
                no_check = 1'b1;
            end else if (w[23:22] > 2'd1) begin
                no_check = 1'b1;                   // reserved shift
            end else if (w[22]) begin
                reg_track[rd] = reg_track[rn] + {40'd0, imm12, 12'd0};
            end else begin
                reg_track[rd] = reg_track[rn] + {52'd0, imm12};
            end
        end else if ((w & MASK_LDR_UO) == OP_LDR_UO) begin
            if (imm12 == '0) no_check = 1'b1;
            else reg_track[rd] = reg_track[rn] + {49'd0, imm12, 3'd0};
        end else if ((w & MASK_ADR) == OP_ADR) begin
            reg_track[rd] = simm21 + pc;
        end else if ((w & MASK_LDR_LIT) == OP_LDR_LIT) begin
            reg_track[rd] = {{43{w[23]}}, w[23:5], 2'b00} + pc;
        end else if ((w & MASK_BL) == OP_BL) begin
            disp = {{36{w[25]}}, w[25:0], 2'b00};
            dest = pc[31:0] + disp[31:0];
            hit  = ({32'd0, dest} == target_q);
        end

        if (!hit && !no_check) hit = (rd != ZR_INDEX) && (reg_track[rd] == target_q);

        if (hit) begin
            scan_hit         = 1'b1;
            res.match        = 1'b1;
            res.match_offset = pc[30:0];
        end else if (l) begin
            res.not_found = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input side: one instruction per call, idles drawn at falling edges
    // ------------------------------------------------------------------
    task automatic drive_insn(input bit s, input bit l, input logic [30:0] ofs,
                              input logic [31:0] w, input bit fixed, input t_result want);
        t_result res;
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid            <= 1'b1;
        i_start_of_scan    <= s;
        i_last_of_scan     <= l;
        i_offset           <= ofs;
        i_instruction_word <= w;
        // hold until the transfer happens
        do @(posedge i_clk); while (!o_ready);
        res = xref_step(s, l, ofs, w);
        exp_results.push_back(fixed ? want : res);
    endtask

    // Rewrite the target only once every result is out and the pipe is drained.
    task automatic set_target(input logic [63:0] v);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (exp_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_target_address_we <= 1'b1;
        i_target_address    <= v;
        @(negedge i_clk);
        i_target_address_we <= 1'b0;
        target_q = v;
    endtask

    function automatic void queue_op(input logic [31:0] w);
        t_insn_item it;
        it.s    = 1'b0;
        it.l    = 1'b0;
        // now and then put junk in the two ignored offset bits
        it.ofs  = gen_pc | (($urandom_range(0, 9) == 0) ? 31'($urandom_range(0, 3)) : 31'd0);
        it.insn = w;
        scan_q.push_back(it);
        gen_pc = gen_pc + 31'd4;
    endfunction

    // ------------------------------------------------------------------
    // Random scan: mostly well-formed, with code that builds the target
    // address in a register (ADRP+ADD/LDR, ADR, LDR literal) or branches
    // to it, mixed with near misses, register chains and plain noise.
    // ------------------------------------------------------------------
    task automatic run_scan();
        int          len;
        int          roll;
        bit          tidy;
        longint      d;
        int          dd;
        logic [4:0]  r;
        logic [20:0] imm21;
        logic [11:0] lo12;
        logic [31:0] w;
        len  = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        tidy = $urandom_range(0, 99) < 85;
        if ($urandom_range(0, 9) < 7) gen_pc = target_q[30:0] - 31'($urandom_range(0, 'h3000));
        else gen_pc = 31'($urandom);
        gen_pc[1:0] = 2'b00;
        scan_q.delete();

        while (scan_q.size() < len) begin
            r    = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
            roll = $urandom_range(0, 99);
            if (roll < 23) begin
                // page + low bits; a quarter of the pages and a fifth of the low bits miss a little
                d = (longint'(target_q) >>> 12) - longint'(gen_pc >> 12);
                imm21 = (d >= -PCREL_SPAN && d < PCREL_SPAN) ? d[20:0] : 21'($urandom);
                if ($urandom_range(0, 3) == 0) imm21 = imm21 + 21'($urandom_range(1, 3));
                queue_op(enc_pcrel(OP_ADRP, r, imm21));
                hot_reg = r;
                lo12 = target_q[11:0];
                if ($urandom_range(0, 4) == 0) lo12 = lo12 ^ 12'($urandom_range(1, 15));
                if (roll >= 15 && lo12[2:0] == 3'd0 && lo12 != '0)
                    queue_op(enc_ldr_uo(5'($urandom_range(0, 7)), r, {3'd0, lo12[11:3]}));
                else
                    queue_op(enc_addi(($urandom_range(0, 1) == 0) ? r : 5'($urandom_range(4, 7)),
                                      r, 2'd0, lo12));
            end else if (roll < 31) begin
                d = longint'(target_q) - longint'(gen_pc);
                if ($urandom_range(0, 4) == 0) d = d + longint'($urandom_range(1, 8));
                imm21 = (d >= -PCREL_SPAN && d < PCREL_SPAN) ? d[20:0] : 21'($urandom);
                queue_op(enc_pcrel(OP_ADR, r, imm21));
                hot_reg = r;
            end else if (roll < 38) begin
                d = longint'(target_q) - longint'(gen_pc);
                if ($urandom_range(0, 4) == 0) d = d + 64'sd4;
                if (d[1:0] == 2'b00 && (d >>> 2) >= -LIT_SPAN && (d >>> 2) < LIT_SPAN)
                    w = enc_ldr_lit(r, d[20:2]);
                else
                    w = enc_ldr_lit(r, 19'($urandom));
                queue_op(w);
                hot_reg = r;
            end else if (roll < 46) begin
                dd = int'(target_q[31:0] - {1'b0, gen_pc});
                if ($urandom_range(0, 4) == 0) dd = dd - 4;
                if (dd[1:0] == 2'b00 && (dd >>> 2) >= -BL_SPAN && (dd >>> 2) < BL_SPAN)
                    w = enc_bl(dd[27:2]);
                else
                    w = enc_bl(26'($urandom));
                queue_op(w);
            end else if (roll < 61) begin
                // chain off the last register that was loaded with an address
                if ($urandom_range(0, 1) == 0)
                    queue_op(enc_addi(r, hot_reg,
                                      ($urandom_range(0, 3) == 0) ? 2'($urandom)
                                                                  : 2'($urandom_range(0, 1)),
                                      12'($urandom_range(0, 'h40))));
                else
                    queue_op(enc_ldr_uo(r, hot_reg, 12'($urandom_range(0, 15))));
            end else if (roll < 81) begin
                // one of the decoded forms with every free bit random
                w = $urandom;
                case ($urandom_range(0, 5))
                    0: w = (w & ~MASK_ADRP)    | OP_ADRP;
                    1: w = (w & ~MASK_ADDI)    | OP_ADDI;
                    2: w = (w & ~MASK_LDR_UO)  | OP_LDR_UO;
                    3: w = (w & ~MASK_ADR)     | OP_ADR;
                    4: w = (w & ~MASK_LDR_LIT) | OP_LDR_LIT;
                    default: w = (w & ~MASK_BL) | OP_BL;
                endcase
                queue_op(w);
            end else begin
                queue_op($urandom);
            end
        end

        foreach (scan_q[i]) begin
            if (tidy) begin
                scan_q[i].s = (i == 0);
                scan_q[i].l = (i == scan_q.size() - 1);
            end else begin
                // broken framing: stray starts and lasts, or none at all
                scan_q[i].s = $urandom_range(0, 9) == 0;
                scan_q[i].l = $urandom_range(0, 4) == 0;
            end
        end

        foreach (scan_q[i]) begin
            calm = (rand_sent >= 250 && rand_sent < 400);
            drive_insn(scan_q[i].s, scan_q[i].l, scan_q[i].ofs, scan_q[i].insn, 1'b0, RES_IDLE);
            rand_sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: ready drawn at falling edges, results checked at rising
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected: match %0b ofs %h nf %0b",
                         $time, o_match, o_match_offset, o_not_found);
                errs++;
            end else begin
                e = exp_results.pop_front();
                if (o_match !== e.match) begin
                    $display("%0t: match expected %0b actual %0b", $time, e.match, o_match);
                    errs++;
                end
                if (o_match_offset !== e.match_offset) begin
                    $display("%0t: match_offset expected %h actual %h",
                             $time, e.match_offset, o_match_offset);
                    errs++;
                end
                if (o_not_found !== e.not_found) begin
                    $display("%0t: not_found expected %0b actual %0b",
                             $time, e.not_found, o_not_found);
                    errs++;
                end
            end
        end
    end

    // Watchdog: a run that stops moving is a failure.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, exp_results.size());
            $display("tb_arm64_address_xref_scanner_unit: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [63:0] phase_tgt [6];
        int          phase_len [6];
        int          phase_base;

        foreach (reg_track[i]) reg_track[i] = '0;
        scan_hit     = 1'b0;
        target_q     = '0;
        errs         = 0;
        quiet_cycles = 0;
        rand_sent    = 0;
        calm         = 1'b0;
        hot_reg      = '0;
        gen_pc       = '0;

        // Directed table. Rows with new_tgt set the target, which holds for the rows after them.
        // reset target of zero: the first zero word hits at offset zero
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b1, 1'b0, 31'h0, 32'h0,
                                     1'b1, RES_HIT_AT_ZERO});
        // all-ones word and top offset: no decode, Rd is 31, single-item scan
        dir_tab.push_back(t_dir_row'{1'b1, DIR_TARGET, 1'b1, 1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
                                     1'b1, RES_NOT_FOUND});
        // x1 = 0x401000, then the special cases that must not disturb x1
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b1, 1'b0, 31'h40_0000,
                                     enc_pcrel(OP_ADRP, 5'd1, 21'h1), 1'b0, RES_IDLE});
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b0, 1'b0, 31'h40_0004,
                                     enc_addi(5'd2, 5'd1, 2'd2, 12'h230), 1'b0, RES_IDLE});
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b0, 1'b0, 31'h40_0008,
                                     enc_addi(5'd3, 5'd31, 2'd0, 12'h230), 1'b0, RES_IDLE});
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b0, 1'b0, 31'h40_000C,
                                     enc_ldr_uo(5'd1, 5'd1, 12'h0), 1'b0, RES_IDLE});
        // BL that misses: check falls through to x16
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b0, 1'b0, 31'h40_0010,
                                     enc_bl(26'h10), 1'b0, RES_IDLE});
        // x6 = x1 + 0x230 hits; ignored offset bits set
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b0, 1'b0, 31'h40_0017,
                                     enc_ldr_uo(5'd6, 5'd1, 12'h46), 1'b0, RES_IDLE});
        // after the hit the scan answers all zero, last included
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b0, 1'b1, 31'h40_0018,
                                     enc_addi(5'd1, 5'd1, 2'd0, 12'h230), 1'b1, RES_IDLE});
        // ADR, LDR literal and BL straight to the target; LDR literal and BL in both directions
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b1, 1'b0, 31'h40_0100,
                                     enc_pcrel(OP_ADR, 5'd5, 21'h1130), 1'b0, RES_IDLE});
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b1, 1'b0, 31'h40_0000,
                                     enc_ldr_lit(5'd7, 19'h48C), 1'b0, RES_IDLE});
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b1, 1'b0, 31'h40_0000,
                                     enc_bl(26'h48C), 1'b0, RES_IDLE});
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b1, 1'b0, 31'h40_1240,
                                     enc_bl(26'h3FF_FFFC), 1'b0, RES_IDLE});
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b1, 1'b0, 31'h40_2000,
                                     enc_ldr_lit(5'd7, 19'h7_FC8C), 1'b0, RES_IDLE});
        // a scan with no reference, then a last with no new start
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b1, 1'b1, 31'h40_0000,
                                     enc_addi(5'd8, 5'd8, 2'd0, 12'h1), 1'b1, RES_NOT_FOUND});
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b0, 1'b1, 31'h40_0004,
                                     INSN_NOP, 1'b1, RES_NOT_FOUND});
        // all-ones target reached through a negative page
        dir_tab.push_back(t_dir_row'{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 31'h0,
                                     enc_pcrel(OP_ADRP, 5'd9, 21'h1F_FFFF), 1'b0, RES_IDLE});
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b0, 1'b0, 31'h4,
                                     enc_addi(5'd9, 5'd9, 2'd0, 12'hFFF), 1'b0, RES_IDLE});
        // BL target is compared as 32 bits, so 2^32 is never a BL hit
        dir_tab.push_back(t_dir_row'{1'b1, 64'h0000_0001_0000_0000, 1'b1, 1'b1, 31'h0,
                                     enc_bl(26'h0), 1'b1, RES_NOT_FOUND});
        // most negative page from the top page, then a shifted add
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b1, 1'b0, 31'h7FFF_F000,
                                     enc_pcrel(OP_ADRP, 5'd10, 21'h10_0000), 1'b0, RES_IDLE});
        dir_tab.push_back(t_dir_row'{1'b0, 64'd0, 1'b0, 1'b1, 31'h7FFF_F004,
                                     enc_addi(5'd11, 5'd10, 2'd1, 12'hFFF), 1'b0, RES_IDLE});

        // Random phases, each under its own target
        phase_tgt[0] = {33'd0, 31'($urandom) & 31'h7FFF_FFFC};  phase_len[0] = 200;
        phase_tgt[1] = 64'd0;                                   phase_len[1] = 40;
        phase_tgt[2] = 64'hFFFF_FFFF_FFFF_FFFF;                 phase_len[2] = 80;
        phase_tgt[3] = {32'd0, $urandom | 32'h8000_0000};       phase_len[3] = 150;
        phase_tgt[4] = {$urandom, $urandom};                    phase_len[4] = 60;
        phase_tgt[5] = 64'($urandom_range(0, 'hFFFF));          phase_len[5] = 170;

        // reset, applied once
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].new_tgt) set_target(dir_tab[k].tgt);
            drive_insn(dir_tab[k].s, dir_tab[k].l, dir_tab[k].ofs, dir_tab[k].insn,
                       dir_tab[k].fixed, dir_tab[k].want);
        end

        for (int p = 0; p < 6; p++) begin
            set_target(phase_tgt[p]);
            phase_base = rand_sent;
            while (rand_sent - phase_base < phase_len[p]) run_scan();
        end

        // drain: the watchdog catches anything that never comes out
        @(negedge i_clk);
        i_valid <= 1'b0;
        calm = 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errs == 0) begin
            $display("tb_arm64_address_xref_scanner_unit: PASS");
        end else begin
            $display("tb_arm64_address_xref_scanner_unit: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
